@@ rtl/msort_pkg.sv @@
// msort_pkg: sizes and sequencer codes for the merge sorter.
// Depends on nothing; used by the channel interfaces, merge_sorter and the testbench.
package msort_pkg;

   localparam int MAX_KEYS = 64;
   localparam int KEY_W    = 32;
   localparam int IDX_W    = $clog2(MAX_KEYS);  // memory address
   localparam int CNT_W    = IDX_W + 1;         // counts 0..MAX_KEYS
   localparam int SPAN_W   = CNT_W + 1;         // lo + 2*width before clamping

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

   // sequencer states
   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_TURN  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

endpackage

@@ rtl/msort_if.sv @@
// Valid/ready channel interfaces for the merge sorter: key beats in, sorted beats out.
// Depends on msort_pkg.

interface msort_req_if
   import msort_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key_value;
   logic                    last;

   modport source (output valid, output key_value, output last, input ready);
   modport sink   (input valid, input key_value, input last, output ready);
endinterface

interface msort_rsp_if
   import msort_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] sorted_value;
   logic                    last_out;
   logic                    overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

@@ rtl/merge_sorter.sv @@
// merge_sorter: bottom-up merge sort of up to MAX_KEYS signed Q16.16 keys.
// Depends on msort_pkg and the channel interfaces in msort_if.sv.
//
// Usage:
//  - req_if carries one key per beat; the beat with last set closes the set.
//    Keys past MAX_KEYS are dropped and flagged; the closing beat still closes.
//  - rsp_if returns every stored key, smallest first, one per beat. last_out
//    marks the final beat, and overflow on that beat reports dropped keys.
//  - Loading takes a key on every beat. After the closing beat the block sorts
//    with one compare/select unit that writes one merged key per cycle, going
//    back and forth between two 64-entry key memories. Each pass starts with a
//    turnaround state for the registered memory reads, and there are ceil(log2 n)
//    passes. Draining moves on with each beat that the sink takes.
//  - req_if.ready is high only while loading; during sort and drain no key is
//    taken. The result sits in an output register: a stalled sink holds the
//    beat and pauses the drain, nothing is lost. After the last result enters
//    that register the block takes keys of the next set again.
//  - Synchronous reset empties the set and clears the overflow flag and the
//    output valid flag. Key memories are not cleared; only written entries are
//    ever read.

module merge_sorter
   import msort_pkg::*;
   (
   input  logic clock,
   input  logic reset,
   msort_req_if.sink   req_if,
   msort_rsp_if.source rsp_if
   );

   // key memories: A holds loaded keys; passes go A->B, B->A, ...
   logic signed [KEY_W-1:0] mem_a [MAX_KEYS];
   logic signed [KEY_W-1:0] mem_b [MAX_KEYS];
   logic signed [KEY_W-1:0] qa_l_ff, qa_r_ff, qb_l_ff, qb_r_ff;

   // sequencer
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] l_ff, l_in;
   logic [CNT_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             sel_ff, sel_in;   // 0: read A write B, 1: read B write A

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    req_beat;
   logic                    room;
   logic [CNT_W-1:0]        cnt_after;
   logic signed [KEY_W-1:0] q_l, q_r;
   logic                    take_left;
   logic signed [KEY_W-1:0] merge_data;
   logic                    seg_end;
   logic [SPAN_W-1:0]       next_lo, next_w;
   logic [SPAN_W-1:0]       setup_lo, setup_w, setup_mid, setup_hi, setup_n;
   logic                    rsp_free;
   logic                    out_final;

   assign req_if.ready = (state_ff == ST_LOAD);
   assign req_beat     = req_if.valid && req_if.ready;
   assign room         = (count_ff < MAX_CNT);
   assign cnt_after    = room ? count_ff + CNT_W'(1) : count_ff;

   assign q_l = sel_ff ? qb_l_ff : qa_l_ff;
   assign q_r = sel_ff ? qb_r_ff : qa_r_ff;

   // the shared compare/select unit
   assign take_left  = (l_ff < mid_ff) && ((r_ff >= hi_ff) || (q_l < q_r));
   assign merge_data = take_left ? q_l : q_r;
   assign seg_end    = (k_ff + CNT_W'(1) == hi_ff);
   assign next_lo    = SPAN_W'(lo_ff) + {width_ff, 1'b0};
   assign next_w     = {width_ff, 1'b0};

   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign out_final = (l_ff + CNT_W'(1) == n_ff);

   // run bounds of the next segment; the tail run merges with an empty right run
   always_comb begin
      if (state_ff == ST_LOAD) begin
         setup_lo = '0;
         setup_w  = SPAN_W'(1);
         setup_n  = SPAN_W'(cnt_after);
      end else if (seg_end && (next_lo < SPAN_W'(n_ff))) begin
         setup_lo = next_lo;
         setup_w  = SPAN_W'(width_ff);
         setup_n  = SPAN_W'(n_ff);
      end else begin
         setup_lo = '0;
         setup_w  = next_w;
         setup_n  = SPAN_W'(n_ff);
      end
      setup_mid = (setup_lo + setup_w < setup_n) ? setup_lo + setup_w : setup_n;
      setup_hi  = (setup_lo + {setup_w[SPAN_W-2:0], 1'b0} < setup_n) ?
                  setup_lo + {setup_w[SPAN_W-2:0], 1'b0} : setup_n;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               count_in = cnt_after;
               if (!room) begin
                  ovf_in = 1'b1;
               end
               if (req_if.last) begin
                  n_in     = cnt_after;
                  width_in = CNT_W'(1);
                  sel_in   = 1'b0;
                  lo_in    = CNT_W'(setup_lo);
                  l_in     = CNT_W'(setup_lo);
                  mid_in   = CNT_W'(setup_mid);
                  r_in     = CNT_W'(setup_mid);
                  hi_in    = CNT_W'(setup_hi);
                  k_in     = CNT_W'(setup_lo);
                  state_in = ST_TURN;
               end
            end
         end
         ST_TURN: begin
            // memory reads of the fresh run heads land here
            state_in = (width_ff >= n_ff) ? ST_OUT : ST_MERGE;
         end
         ST_MERGE: begin
            l_in = l_ff + CNT_W'(take_left);
            r_in = r_ff + CNT_W'(!take_left);
            k_in = k_ff + CNT_W'(1);
            if (seg_end) begin
               lo_in  = CNT_W'(setup_lo);
               l_in   = CNT_W'(setup_lo);
               mid_in = CNT_W'(setup_mid);
               r_in   = CNT_W'(setup_mid);
               hi_in  = CNT_W'(setup_hi);
               k_in   = CNT_W'(setup_lo);
               if (!(next_lo < SPAN_W'(n_ff))) begin
                  // pass done: swap memories, double the run width
                  width_in = CNT_W'(next_w);
                  sel_in   = !sel_ff;
                  state_in = ST_TURN;
               end
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = q_l;
               rsp_last_in  = out_final;
               rsp_ovf_in   = out_final && ovf_ff;
               l_in         = l_ff + CNT_W'(1);
               if (out_final) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      width_ff     <= width_in;
      lo_ff        <= lo_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // memory A: loaded keys, and destination of even-numbered passes
   always_ff @(posedge clock) begin
      if (req_beat && room) begin
         mem_a[count_ff[IDX_W-1:0]] <= req_if.key_value;
      end else if ((state_ff == ST_MERGE) && sel_ff) begin
         mem_a[k_ff[IDX_W-1:0]] <= merge_data;
      end
      qa_l_ff <= mem_a[l_in[IDX_W-1:0]];
      qa_r_ff <= mem_a[r_in[IDX_W-1:0]];
   end

   // memory B: destination of odd-numbered passes (the first pass writes B)
   always_ff @(posedge clock) begin
      if ((state_ff == ST_MERGE) && !sel_ff) begin
         mem_b[k_ff[IDX_W-1:0]] <= merge_data;
      end
      qb_l_ff <= mem_b[l_in[IDX_W-1:0]];
      qb_r_ff <= mem_b[r_in[IDX_W-1:0]];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sorted_value = rsp_value_ff;
   assign rsp_if.last_out     = rsp_last_ff;
   assign rsp_if.overflow     = rsp_ovf_ff;

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for merge_sorter, driving key sets and checking sorted beats.
// Depends on msort_pkg and the msort_req_if / msort_rsp_if channel interfaces.
// Expected beats come from a behavioral sort kept here; mismatches are reported and counted.

module testbench
   import msort_pkg::*;
   ();

   localparam int HALF_PERIOD    = 2;
   localparam int CALM_TAIL      = 30;    // last beats are sent and taken with no idling
   localparam int LONG_HOLD      = 600;   // receiver hold-off, longer than a full 64-key sort
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES   = 20;    // settle time after the last expected beat
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic                    last;
   } key_beat_type;

   typedef struct {
      logic signed [KEY_W-1:0] sorted_value;
      logic                    last_out;
      logic                    overflow;
   } sorted_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msort_req_if req_bus ();
   msort_rsp_if rsp_bus ();

   merge_sorter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Stimulus store and shadow of the sorter's set
   // ---------------------------------------------------------------------
   key_beat_type    key_beats[$];       // beats not yet offered to the block
   sorted_beat_type sorted_exp[$];      // sorted beats still owed by the block

   logic signed [KEY_W-1:0] held_keys[MAX_KEYS];
   int                      held_count = 0;
   logic                    keys_dropped = 1'b0;

   int mismatch_count = 0;
   int send_gap = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int quiet_cycles = 0;
   key_beat_type next_beat;

   task automatic push_key(input logic signed [KEY_W-1:0] key, input logic last);
      key_beat_type b;
      b.key  = key;
      b.last = last;
      key_beats.push_back(b);
   endtask

   // Mix of extremes, a narrow band near zero (forces equal keys) and full-range values.
   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(KEY_W-1){1'b0}}};
         1: return {1'b0, {(KEY_W-1){1'b1}}};
         2, 3: return KEY_W'($signed($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // A set of random keys; only its final beat carries last.
   task automatic push_set(input int size);
      for (int i = 0; i < size; i++) begin
         push_key(pick_key(), i == size - 1);
      end
   endtask

   // Sorts the held keys and queues one expected beat per key. Equal keys are
   // indistinguishable, so a plain insertion sort gives the same sequence.
   task automatic close_set();
      logic signed [KEY_W-1:0] ordered[MAX_KEYS];
      logic signed [KEY_W-1:0] pick;
      sorted_beat_type         beat;
      int                      j;
      for (int i = 0; i < held_count; i++) begin
         pick = held_keys[i];
         j    = i;
         while (j > 0 && ordered[j-1] > pick) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = pick;
      end
      for (int i = 0; i < held_count; i++) begin
         beat.sorted_value = ordered[i];
         beat.last_out     = (i == held_count - 1);
         beat.overflow     = (i == held_count - 1) ? keys_dropped : 1'b0;
         sorted_exp.push_back(beat);
      end
      held_count   = 0;
      keys_dropped = 1'b0;
   endtask

   // One accepted key beat: store it or, with the store full, drop it and
   // remember the overflow. The closing beat closes the set either way.
   task automatic load_key(input logic signed [KEY_W-1:0] key, input logic last);
      if (held_count < MAX_KEYS) begin
         held_keys[held_count] = key;
         held_count++;
      end else begin
         keys_dropped = 1'b1;
      end
      if (last) begin
         close_set();
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   task automatic check_sorted(input logic signed [KEY_W-1:0] value, input logic last_out,
                               input logic overflow);
      sorted_beat_type want;
      if (sorted_exp.size() == 0) begin
         note_mismatch($sformatf("unexpected beat value=%0d last_out=%b overflow=%b",
                                 value, last_out, overflow));
      end else begin
         want = sorted_exp.pop_front();
         if (value !== want.sorted_value || last_out !== want.last_out ||
             overflow !== want.overflow) begin
            note_mismatch($sformatf(
               "expected value=%0d last_out=%b overflow=%b, got value=%0d last_out=%b overflow=%b",
               want.sorted_value, want.last_out, want.overflow, value, last_out, overflow));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued key beats, holds a beat until it is taken, and
   // inserts random idle bursts except in the calm tail.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            load_key(req_bus.key_value, req_bus.last);
         end
         // The slot is free once the current beat has been taken.
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (key_beats.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (key_beats.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_bus.valid <= 1'b0;
            end else begin
               next_beat = key_beats.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.key_value <= next_beat.key;
               req_bus.last      <= next_beat.last;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each taken result beat and drives ready. Once, after a
   // large set closes, ready is held low through the LONG_HOLD hold-off while the driver
   // keeps offering the next set, so the block backs up and stalls its input.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_sorted(rsp_bus.sorted_value, rsp_bus.last_out, rsp_bus.overflow);
         end
         if (!long_hold_done && sorted_exp.size() >= MAX_KEYS / 2) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (key_beats.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: a correct run never goes this long without a beat on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus plan, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int small_items;
      int set_idx;
      int size;

      req_bus.valid     = 1'b0;
      req_bus.key_value = '0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;

      // Directed sets.
      // Single-key set: sorts to itself, last_out on the only beat.
      push_key(32'sh7FFF_FFFF, 1'b1);
      // Field extremes, zero, +-1 and one in Q16.16, unsorted.
      push_key(32'sh8000_0000, 1'b0);
      push_key(32'sh7FFF_FFFF, 1'b0);
      push_key(32'sh0000_0000, 1'b0);
      push_key(-32'sd1,        1'b0);
      push_key(32'sh0000_0001, 1'b0);
      push_key(32'sh0001_0000, 1'b1);
      // Equal keys.
      push_key(32'sd5,  1'b0);
      push_key(32'sd5,  1'b0);
      push_key(-32'sd5, 1'b0);
      push_key(32'sd5,  1'b1);
      // Two equal minimum keys.
      push_key(32'sh8000_0000, 1'b0);
      push_key(32'sh8000_0000, 1'b1);
      // Already ascending.
      push_key(-32'sd300, 1'b0);
      push_key(-32'sd2,   1'b0);
      push_key(32'sd7,    1'b0);
      push_key(32'sd1000, 1'b1);
      // Descending, odd count so the last merge pass has a short run.
      push_key(32'sh4000_0000, 1'b0);
      push_key(32'sh0000_8000, 1'b0);
      push_key(32'sd0,         1'b0);
      push_key(-32'sd65536,    1'b0);
      push_key(32'shC000_0000, 1'b1);

      // Random sets, mostly small. Set 2 fills the store and runs past it, so
      // the last two keys, the closing one among them, are dropped and
      // overflow shows.
      small_items = 0;
      set_idx     = 0;
      while (set_idx < 4 || small_items < 25) begin
         if (set_idx == 2) begin
            push_set(MAX_KEYS + 2);
         end else begin
            size = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
            push_set(size);
            small_items += size;
         end
         set_idx++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Everything sent and every sorted beat back, then a short settle.
      while (key_beats.size() != 0 || req_bus.valid || sorted_exp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ merge_sorter.f @@
rtl/msort_pkg.sv
rtl/msort_if.sv
rtl/merge_sorter.sv
tb/testbench.sv
